// ----- hdl/stt_pkg.sv -----
// Shared types and constants for the source text tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Character classes found by the front
   typedef enum logic [2:0] {
      CLS_SPACE,
      CLS_WORD,    // letter or underscore
      CLS_DIGIT,
      CLS_DOT,
      CLS_QUOTE,
      CLS_SYM,
      CLS_OTHER
   } char_class_type;

   // Scanner state in the back
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_IDENT,
      ST_INT,
      ST_FRAC,
      ST_STR,
      ST_STOP
   } scan_state_type;

   // Token kinds on the result channel
   typedef enum logic [2:0] {
      KIND_ID,
      KIND_NUM,
      KIND_STR,
      KIND_SYM,
      KIND_UNK,
      KIND_END
   } token_kind_type;

   // One classified input transaction, as queued between front and back
   typedef struct packed {
      logic [7:0]     data;
      logic           eot;
      char_class_type cls;
   } entry_type;

   // One result transaction
   typedef struct packed {
      token_kind_type kind;
      logic           has;
      logic [7:0]     data;
      logic           first;
      logic           done;
      logic           last;
   } result_type;

endpackage

// ----- hdl/source_text_tokenizer.sv -----
// Top level of the source text tokenizer.
`timescale 1ns / 1ps

// Source text tokenizer.
// Input channel (req_): one source byte per transaction, or an end-of-text
// marker. Result channel (rsp_): token items, at most one token character
// each, with kind, first/done flags and run_last on the final item caused by
// an input. The front classifies each accepted byte and writes it into a
// small queue (QUEUE_DEPTH entries); the back runs the scanner and drives a
// registered output. An accepted input is written into the queue; the back
// loads its result into the output register. Throughput is one byte per
// cycle while rsp_ready stays high; a byte that closes an identifier or
// number and opens a new token yields two items and holds the queue head
// until both are loaded, as does end of text with a token open, since the
// back has a single output register. Bytes that yield no item (spaces, the
// number dot) pop without waiting for the output register. An unknown byte
// outside a string or end of text stops the scanner: later inputs are taken
// and dropped until reset. Reset empties the queue and the output register
// and returns the scanner to idle between tokens. When the receiver holds
// rsp_ready low the back stalls, the queue fills, and req_ready then drops.
module source_text_tokenizer #(
   parameter int QUEUE_DEPTH = stt_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_token_kind,
   output logic       rsp_has_byte,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_token_first,
   output logic       rsp_token_done,
   output logic       rsp_run_last
);

   logic                head_valid;
   logic                head_pop;
   stt_pkg::entry_type  head;
   stt_pkg::result_type rsp;

   stt_front #(
      .DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .head_valid      (head_valid),
      .head            (head),
      .head_pop        (head_pop)
   );

   stt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   // Unpack the result transaction onto its ports
   assign rsp_token_kind  = 3'(rsp.kind);
   assign rsp_has_byte    = rsp.has;
   assign rsp_token_byte  = rsp.data;
   assign rsp_token_first = rsp.first;
   assign rsp_token_done  = rsp.done;
   assign rsp_run_last    = rsp.last;

endmodule

// ----- hdl/stt_front.sv -----
// Front end: classify incoming bytes and queue them for the scanner.
`timescale 1ns / 1ps

module stt_front #(
   parameter int DEPTH = stt_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_text_byte,
   input  logic               req_end_of_text,
   output logic               head_valid,
   output stt_pkg::entry_type head,
   input  logic               head_pop
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   stt_pkg::entry_type queue_mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               push;
   logic               pop;
   stt_pkg::entry_type new_entry;

   // Classify one raw byte
   function automatic stt_pkg::char_class_type classify(input logic [7:0] b);
      stt_pkg::char_class_type c;
      c = stt_pkg::CLS_OTHER;
      if (b == 8'h20) begin
         c = stt_pkg::CLS_SPACE;
      end else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
                   b == 8'h5F) begin
         c = stt_pkg::CLS_WORD;
      end else if (b >= 8'h30 && b <= 8'h39) begin
         c = stt_pkg::CLS_DIGIT;
      end else if (b == 8'h2E) begin
         c = stt_pkg::CLS_DOT;
      end else if (b == 8'h22 || b == 8'h27) begin
         c = stt_pkg::CLS_QUOTE;
      end else begin
         case (b) inside
            8'h3B, 8'h21, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29, 8'h2D, 8'h2B,
            8'h3D, 8'h7B, 8'h7D, 8'h7C, 8'h3C, 8'h3E, 8'h2F, 8'h3A, 8'h5B,
            8'h5D: c = stt_pkg::CLS_SYM;
            default: c = stt_pkg::CLS_OTHER;
         endcase
      end
      return c;
   endfunction

   // Build the queue entry
   always_comb begin
      new_entry.data = req_text_byte;
      new_entry.eot  = req_end_of_text;
      new_entry.cls  = classify(req_text_byte);
   end

   assign req_ready  = (fill_ff != FILL_W'(DEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (fill_ff != '0);
   assign pop        = head_pop && head_valid;
   assign head       = queue_mem[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the classified transaction
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// ----- hdl/stt_back.sv -----
// Back end: scanner state machine and registered result output.
`timescale 1ns / 1ps

module stt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  stt_pkg::entry_type  head,
   output logic                head_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output stt_pkg::result_type rsp
);

   stt_pkg::scan_state_type state_ff, state_in;
   logic                    phase_ff, phase_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   stt_pkg::result_type     rsp_ff, rsp_in;

   stt_pkg::result_type     r0, r1, fres;
   logic                    f_has;
   stt_pkg::scan_state_type f_state;
   logic [1:0]              cnt;
   logic                    out_free;
   logic                    load;

   function automatic stt_pkg::result_type mk(input stt_pkg::token_kind_type k,
                                              input logic has,
                                              input logic [7:0] d,
                                              input logic first,
                                              input logic done);
      stt_pkg::result_type r;
      r.kind  = k;
      r.has   = has;
      r.data  = has ? d : 8'h00;
      r.first = first;
      r.done  = done;
      r.last  = 1'b0;
      return r;
   endfunction

   function automatic stt_pkg::token_kind_type open_kind(input stt_pkg::scan_state_type s);
      stt_pkg::token_kind_type k;
      case (s)
         stt_pkg::ST_IDENT: k = stt_pkg::KIND_ID;
         stt_pkg::ST_STR:   k = stt_pkg::KIND_STR;
         default:           k = stt_pkg::KIND_NUM;
      endcase
      return k;
   endfunction

   // Handle a byte seen between tokens
   always_comb begin
      f_has   = 1'b1;
      f_state = stt_pkg::ST_IDLE;
      fres    = mk(stt_pkg::KIND_UNK, 1'b0, 8'h00, 1'b1, 1'b1);
      case (head.cls)
         stt_pkg::CLS_SPACE: begin
            f_has = 1'b0;
         end
         stt_pkg::CLS_WORD: begin
            fres    = mk(stt_pkg::KIND_ID, 1'b1, head.data, 1'b1, 1'b0);
            f_state = stt_pkg::ST_IDENT;
         end
         stt_pkg::CLS_DIGIT: begin
            fres    = mk(stt_pkg::KIND_NUM, 1'b1, head.data, 1'b1, 1'b0);
            f_state = stt_pkg::ST_INT;
         end
         stt_pkg::CLS_QUOTE: begin
            fres    = mk(stt_pkg::KIND_STR, 1'b0, 8'h00, 1'b1, 1'b0);
            f_state = stt_pkg::ST_STR;
         end
         stt_pkg::CLS_SYM: begin
            fres = mk(stt_pkg::KIND_SYM, 1'b1, head.data, 1'b1, 1'b1);
         end
         default: begin
            f_state = stt_pkg::ST_STOP;
         end
      endcase
   end

   // Work out the results of the head transaction and the next scan state
   always_comb begin
      r0       = mk(open_kind(state_ff), 1'b0, 8'h00, 1'b0, 1'b1);
      r1       = fres;
      cnt      = 2'd0;
      state_in = state_ff;
      if (state_ff == stt_pkg::ST_STOP) begin
         cnt = 2'd0;
      end else if (head.eot) begin
         state_in = stt_pkg::ST_STOP;
         r1       = mk(stt_pkg::KIND_END, 1'b0, 8'h00, 1'b1, 1'b1);
         if (state_ff == stt_pkg::ST_IDLE) begin
            r0  = r1;
            cnt = 2'd1;
         end else begin
            cnt = 2'd2;
         end
      end else begin
         case (state_ff)
            stt_pkg::ST_IDENT: begin
               if (head.cls == stt_pkg::CLS_WORD || head.cls == stt_pkg::CLS_DIGIT) begin
                  r0  = mk(stt_pkg::KIND_ID, 1'b1, head.data, 1'b0, 1'b0);
                  cnt = 2'd1;
               end else begin
                  cnt      = f_has ? 2'd2 : 2'd1;
                  state_in = f_state;
               end
            end
            stt_pkg::ST_INT, stt_pkg::ST_FRAC: begin
               if (head.cls == stt_pkg::CLS_DIGIT) begin
                  r0  = mk(stt_pkg::KIND_NUM, 1'b1, head.data, 1'b0, 1'b0);
                  cnt = 2'd1;
               end else if (head.cls == stt_pkg::CLS_DOT && state_ff == stt_pkg::ST_INT) begin
                  cnt      = 2'd0;
                  state_in = stt_pkg::ST_FRAC;
               end else begin
                  cnt      = f_has ? 2'd2 : 2'd1;
                  state_in = f_state;
               end
            end
            stt_pkg::ST_STR: begin
               cnt = 2'd1;
               if (head.cls == stt_pkg::CLS_QUOTE) begin
                  state_in = stt_pkg::ST_IDLE;
               end else begin
                  r0 = mk(stt_pkg::KIND_STR, 1'b1, head.data, 1'b0, 1'b0);
               end
            end
            default: begin
               r0       = fres;
               cnt      = f_has ? 2'd1 : 2'd0;
               state_in = f_state;
            end
         endcase
      end
   end

   // Load the output register; pop each head after its last result (if any)
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      load         = head_valid && (cnt != 2'd0) && out_free;
      head_pop     = head_valid && ((cnt == 2'd0) ||
                                    (load && (cnt == 2'd1 || phase_ff)));
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = phase_ff ? r1 : r0;
         rsp_in.last  = (cnt == 2'd1) || phase_ff;
         phase_in     = (cnt == 2'd2) && !phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stt_pkg::ST_IDLE;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (head_pop) begin
            state_ff <= state_in;
         end
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // A pending second result keeps its transaction at the queue head
   a_phase_has_head : assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (head_valid && cnt == 2'd2))
      else $error("second result pending without a two-result head");

   // The stopped state is left only through reset
   a_stop_sticky : assert property (@(posedge clock) disable iff (reset)
      state_ff == stt_pkg::ST_STOP |=> state_ff == stt_pkg::ST_STOP)
      else $error("scanner left the stopped state");

   // End and unknown items are always the last result of their transaction
   a_end_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.kind == stt_pkg::KIND_END ||
                        rsp_ff.kind == stt_pkg::KIND_UNK)) |-> rsp_ff.last)
      else $error("end or unknown item not marked last");

   // Loading the first of two results never pops the head
   a_no_early_pop : assert property (@(posedge clock) disable iff (reset)
      (load && !phase_ff && cnt == 2'd2) |-> !head_pop)
      else $error("head popped before its second result");

endmodule
